// File: rtl/pcmrms_pkg.sv
`timescale 1ns / 1ps

package pcmrms_pkg;

  // Field widths
  localparam int WORD_W   = 32;
  localparam int SAMPLE_W = 16;
  localparam int SQ_W     = 31;
  localparam int SUM_W    = 47;
  localparam int LEN_W    = 17;
  localparam int RMS_W    = 24;

  // Alignment and window limits
  localparam int ALIGN_SHIFT = 11;
  localparam int MAX_WINDOW  = 65536;
  localparam logic [LEN_W-1:0] WINLEN_RESET = LEN_W'(16000);
  localparam logic [LEN_W-1:0] WINLEN_MAX   = LEN_W'(MAX_WINDOW);
  localparam logic [LEN_W-1:0] WINLEN_MIN   = LEN_W'(1);

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Back-end divide and root
  localparam int FRAC_SHIFT = 16;
  localparam int DIV_STEPS  = SUM_W + FRAC_SHIFT;
  localparam int WK_W       = 64;
  localparam int ROOT_W     = WK_W / 2;
  localparam int ROOT_STEPS = WK_W / 2;
  localparam int RREM_W     = ROOT_W + 2;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic [SUM_W-1:0]           sum;
    logic [LEN_W-1:0]           len;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

  // Arithmetic shift right, then clamp to signed 16 bits
  function automatic logic signed [SAMPLE_W-1:0] align_sat(input logic [WORD_W-1:0] w);
    logic signed [WORD_W-1:0] sh;
    logic signed [SAMPLE_W-1:0] res;
    sh = $signed(w) >>> ALIGN_SHIFT;
    if (sh[WORD_W-1:SAMPLE_W-1] == {(WORD_W-SAMPLE_W+1){sh[WORD_W-1]}}) begin
      res = sh[SAMPLE_W-1:0];
    end else if (sh[WORD_W-1]) begin
      res = SAMPLE_MIN;
    end else begin
      res = SAMPLE_MAX;
    end
    return res;
  endfunction

  // Clamp a written window length to the supported range
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] res;
    if (v == '0) begin
      res = WINLEN_MIN;
    end else if (v > WINLEN_MAX) begin
      res = WINLEN_MAX;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// File: rtl/pcm_align_saturate_rms_meter.sv
`timescale 1ns / 1ps
// Channel   Ports                                   Handshake
// input     in_left_word                            in_push / in_full
// result    out_sample, out_window_last, out_rms    out_empty / out_pop
// config    cfg_window_len                          cfg_wr_en
//
// An ordinary word passes from the front stage register through the queue to the result register;
// the front takes one word a cycle while the two-entry queue has room.
// A window-closing word holds the back part through a load step, the divide steps
// and the root steps; words behind it wait in the queue.
// Reset (rst_n low, synchronous) empties both sides and loads window length 16000.
// A full result stage stalls the back part; a full queue and front stage raise in_full.

module pcm_align_saturate_rms_meter import pcmrms_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [WORD_W-1:0]          in_left_word,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic                       out_window_last,
  output logic [RMS_W-1:0]           out_rms,
  input  logic                       cfg_wr_en,
  input  logic [LEN_W-1:0]           cfg_window_len
);

  q_push_t q_wr;
  q_head_t q_head;
  logic    q_full;
  logic    q_pop;

  pcmrms_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_left_word   (in_left_word),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_window_len (cfg_window_len),
    .q_full         (q_full),
    .q_wr           (q_wr)
  );

  pcmrms_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  pcmrms_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_sample      (out_sample),
    .out_window_last (out_window_last),
    .out_rms         (out_rms)
  );

endmodule

// File: rtl/pcmrms_front.sv
`timescale 1ns / 1ps

module pcmrms_front import pcmrms_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [WORD_W-1:0] in_left_word,
  input  logic              cfg_wr_en,
  input  logic [LEN_W-1:0]  cfg_window_len,
  input  logic              q_full,
  output q_push_t           q_wr
);

  logic                       s1_v_r, s1_v_nxt;
  logic signed [SAMPLE_W-1:0] s1_sample_r, s1_sample_nxt;
  logic [SQ_W-1:0]            s1_sq_r, s1_sq_nxt;
  logic [SUM_W-1:0]           sum_r, sum_nxt;
  logic [LEN_W-1:0]           cnt_r, cnt_nxt;
  logic [LEN_W-1:0]           len_r, len_nxt;

  logic                       accept;
  logic                       advance;
  logic signed [SAMPLE_W-1:0] aligned;
  logic signed [2*SAMPLE_W-1:0] prod;
  logic [SUM_W-1:0]           sum_add;
  logic [LEN_W-1:0]           cnt_inc;
  logic                       last;

  assign in_full = s1_v_r & q_full;
  assign accept  = in_push & ~in_full;
  assign advance = s1_v_r & ~q_full;

  // Stage 1: align, clamp and square the incoming word
  assign aligned = align_sat(in_left_word);
  assign prod    = aligned * aligned;

  // Stage 2: accumulate and close the window
  assign sum_add = sum_r + SUM_W'(s1_sq_r);
  assign cnt_inc = cnt_r + LEN_W'(1);
  assign last    = (cnt_inc >= len_r);

  always_comb begin
    s1_v_nxt      = accept | (s1_v_r & q_full);
    s1_sample_nxt = accept ? aligned : s1_sample_r;
    s1_sq_nxt     = accept ? prod[SQ_W-1:0] : s1_sq_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    len_nxt       = cfg_wr_en ? eff_len(cfg_window_len) : len_r;
    if (advance) begin
      sum_nxt = last ? '0 : sum_add;
      cnt_nxt = last ? '0 : cnt_inc;
    end
  end

  // Push the classified word into the queue
  always_comb begin
    q_wr.push         = advance;
    q_wr.entry.sample = s1_sample_r;
    q_wr.entry.last   = last;
    q_wr.entry.sum    = sum_add;
    q_wr.entry.len    = len_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      sum_r  <= '0;
      cnt_r  <= '0;
      len_r  <= WINLEN_RESET;
    end else begin
      s1_v_r <= s1_v_nxt;
      sum_r  <= sum_nxt;
      cnt_r  <= cnt_nxt;
      len_r  <= len_nxt;
    end
    s1_sample_r <= s1_sample_nxt;
    s1_sq_r     <= s1_sq_nxt;
  end

endmodule

// File: rtl/pcmrms_queue.sv
`timescale 1ns / 1ps

module pcmrms_queue import pcmrms_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  q_push_t q_wr,
  output logic    q_full,
  output q_head_t q_head,
  input  logic    q_pop
);

  q_entry_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign q_full       = (cnt_r == QCNT_W'(QDEPTH));
  assign q_head.valid = (cnt_r != '0);
  assign q_head.entry = mem_r[rd_ptr_r];

  assign do_push = q_wr.push & ~q_full;
  assign do_pop  = q_pop & q_head.valid;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_wr.entry;
    end
  end

endmodule

// File: rtl/pcmrms_back.sv
`timescale 1ns / 1ps

module pcmrms_back import pcmrms_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  q_head_t                    q_head,
  output logic                       q_pop,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic                       out_window_last,
  output logic [RMS_W-1:0]           out_rms
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROOT
  } state_t;

  state_t                     state_r, state_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [WK_W-1:0]            wk_r, wk_nxt;
  logic [LEN_W-1:0]           divisor_r, divisor_nxt;
  logic [LEN_W-1:0]           drem_r, drem_nxt;
  logic [RREM_W-1:0]          rrem_r, rrem_nxt;
  logic [ROOT_W-1:0]          root_r, root_nxt;
  logic signed [SAMPLE_W-1:0] hold_sample_r, hold_sample_nxt;

  logic                       out_v_r, out_v_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic                       out_last_r, out_last_nxt;
  logic [RMS_W-1:0]           out_rms_r, out_rms_nxt;

  logic                       out_free;
  logic [LEN_W:0]             drem_sh;
  logic                       div_ge;
  logic [RREM_W+1:0]          rrem_sh;
  logic [RREM_W+1:0]          trial;
  logic                       root_ge;
  logic [ROOT_W-1:0]          root_fin;
  logic [RMS_W-1:0]           rms_sat;

  assign out_empty       = ~out_v_r;
  assign out_sample      = out_sample_r;
  assign out_window_last = out_last_r;
  assign out_rms         = out_rms_r;

  assign out_free = ~out_v_r | out_pop;

  // Restoring divide step: one quotient bit a cycle
  assign drem_sh = {drem_r, wk_r[DIV_STEPS-1]};
  assign div_ge  = (drem_sh >= {1'b0, divisor_r});

  // Digit-by-digit square root step: one root bit a cycle
  assign rrem_sh  = {rrem_r, wk_r[WK_W-1 -: 2]};
  assign trial    = {2'b00, root_r, 2'b01};
  assign root_ge  = (rrem_sh >= trial);
  assign root_fin = {root_r[ROOT_W-2:0], root_ge};
  assign rms_sat  = (root_fin[ROOT_W-1:RMS_W] != '0) ? '1 : root_fin[RMS_W-1:0];

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    wk_nxt          = wk_r;
    divisor_nxt     = divisor_r;
    drem_nxt        = drem_r;
    rrem_nxt        = rrem_r;
    root_nxt        = root_r;
    hold_sample_nxt = hold_sample_r;
    out_v_nxt       = out_v_r & ~out_pop;
    out_sample_nxt  = out_sample_r;
    out_last_nxt    = out_last_r;
    out_rms_nxt     = out_rms_r;
    q_pop           = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_head.valid && out_free) begin
          q_pop = 1'b1;
          if (!q_head.entry.last) begin
            // Pass an ordinary word straight to the output
            out_v_nxt      = 1'b1;
            out_sample_nxt = q_head.entry.sample;
            out_last_nxt   = 1'b0;
            out_rms_nxt    = '0;
          end else begin
            // Load the scaled sum for the divide
            state_nxt       = ST_DIV;
            cnt_nxt         = CNT_W'(DIV_STEPS - 1);
            wk_nxt          = {1'b0, q_head.entry.sum, {FRAC_SHIFT{1'b0}}};
            divisor_nxt     = q_head.entry.len;
            drem_nxt        = '0;
            hold_sample_nxt = q_head.entry.sample;
          end
        end
      end
      ST_DIV: begin
        drem_nxt = div_ge ? LEN_W'(drem_sh - {1'b0, divisor_r}) : drem_sh[LEN_W-1:0];
        wk_nxt   = {1'b0, wk_r[DIV_STEPS-2:0], div_ge};
        cnt_nxt  = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_ROOT;
          cnt_nxt   = CNT_W'(ROOT_STEPS - 1);
          rrem_nxt  = '0;
          root_nxt  = '0;
        end
      end
      ST_ROOT: begin
        rrem_nxt = root_ge ? RREM_W'(rrem_sh - trial) : rrem_sh[RREM_W-1:0];
        root_nxt = root_fin;
        wk_nxt   = {wk_r[WK_W-3:0], 2'b00};
        cnt_nxt  = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          // Output register is free here: it was free when the window started
          state_nxt      = ST_IDLE;
          out_v_nxt      = 1'b1;
          out_sample_nxt = hold_sample_r;
          out_last_nxt   = 1'b1;
          out_rms_nxt    = rms_sat;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
    end
    cnt_r         <= cnt_nxt;
    wk_r          <= wk_nxt;
    divisor_r     <= divisor_nxt;
    drem_r        <= drem_nxt;
    rrem_r        <= rrem_nxt;
    root_r        <= root_nxt;
    hold_sample_r <= hold_sample_nxt;
    out_sample_r  <= out_sample_nxt;
    out_last_r    <= out_last_nxt;
    out_rms_r     <= out_rms_nxt;
  end

endmodule

// File: rtl/pcmrms_checker.sv
`timescale 1ns / 1ps

module pcmrms_checker import pcmrms_pkg::*; (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_full,
  input logic                       out_empty,
  input logic                       out_pop,
  input logic signed [SAMPLE_W-1:0] out_sample,
  input logic                       out_window_last,
  input logic [RMS_W-1:0]           out_rms
);

  // Reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result pending after reset");

  // Reset leaves the input side open
  a_reset_open: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full after reset");

  // Only a window-closing word carries a level
  a_rms_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_window_last) |-> (out_rms == '0))
    else $error("rms set on a word that does not close the window");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_sample) && $stable(out_window_last) && $stable(out_rms)))
    else $error("stalled result changed");

endmodule

bind pcm_align_saturate_rms_meter pcmrms_checker u_chk (.*);
